>>> design/tbp_pkg.sv
// Package for the tournament branch predictor.
// Holds the field widths, table geometry, shared types, opcode and register codes, and counter and history helpers.
// No dependencies; every other design file refers to it by scoped names.
package tbp_pkg;

    localparam int SLOT_W    = 3;
    localparam int LHIST_W   = 3;
    localparam int GHIST_W   = 6;
    localparam int HB_W      = 3;
    localparam int CTR_W     = 2;
    localparam int LIDX_W    = SLOT_W + LHIST_W;
    localparam int NUM_SLOTS = 1 << SLOT_W;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int IN_DW     = 8;
    localparam int OUT_DW    = 8;

    localparam logic [HB_W-1:0] MAX_GBITS = HB_W'(GHIST_W);
    localparam logic            OP_BRANCH = 1'b0;
    localparam logic            OP_CLEAR  = 1'b1;
    localparam logic            REG_HIST_BITS = 1'b0;
    localparam logic            REG_INIT_ONES = 1'b1;

    typedef struct packed {
        logic [HB_W-1:0] history_bits;
        logic            init_all_ones;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [LIDX_W-1:0] addr;
        logic [CTR_W-1:0]  data;
    } tbl_wr_t;

    function automatic logic [CTR_W-1:0] sat_move(input logic [CTR_W-1:0] c, input logic up);
        logic [CTR_W-1:0] r;
        if (up)
        begin
            r = (c == {CTR_W{1'b1}}) ? c : c + CTR_W'(1);
        end
        else
        begin
            r = (c == '0) ? c : c - CTR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [HB_W-1:0] eff_bits(input logic [HB_W-1:0] hb);
        logic [HB_W-1:0] p;
        p = hb;
        if (hb == '0)
        begin
            p = HB_W'(1);
        end
        else if (hb > MAX_GBITS)
        begin
            p = MAX_GBITS;
        end
        return p;
    endfunction

    function automatic logic [GHIST_W-1:0] gmask(input logic [HB_W-1:0] p);
        return ~({GHIST_W{1'b1}} << p);
    endfunction

endpackage

>>> design/tbp_apb_regs.sv
// Configuration registers of the tournament branch predictor on an APB port.
// Holds the global history length and the clear fill select.
// Depends on tbp_pkg.
module tbp_apb_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tbp_pkg::APB_AW-1:0] paddr,
    input  logic [tbp_pkg::APB_DW-1:0] pwdata,
    output logic [tbp_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output tbp_pkg::cfg_t              cfg
);

    tbp_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.history_bits  <= tbp_pkg::HB_W'(3);
            cfg_reg.init_all_ones <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                tbp_pkg::REG_HIST_BITS: cfg_reg.history_bits <= pwdata[tbp_pkg::HB_W-1:0];
                tbp_pkg::REG_INIT_ONES: cfg_reg.init_all_ones <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            tbp_pkg::REG_HIST_BITS: prdata[tbp_pkg::HB_W-1:0] = cfg_reg.history_bits;
            tbp_pkg::REG_INIT_ONES: prdata[0] = cfg_reg.init_all_ones;
            default: prdata = '0;
        endcase
    end

endmodule

>>> design/tbp_ctr_tbl.sv
// One 64-entry table of 2-bit saturating counters with per-entry valid bits.
// An entry that is not valid reads as the fill value of the last clear.
// Depends on tbp_pkg.
module tbp_ctr_tbl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [tbp_pkg::LIDX_W-1:0]  rd_addr,
    input  tbp_pkg::tbl_wr_t            wr,
    input  logic                        clr,
    input  logic [tbp_pkg::CTR_W-1:0]   clr_fill,
    output logic [tbp_pkg::CTR_W-1:0]   rd_data
);

    localparam int DEPTH = 1 << tbp_pkg::LIDX_W;

    logic [tbp_pkg::CTR_W-1:0] mem [DEPTH];
    logic [tbp_pkg::CTR_W-1:0] rd_mem_reg;
    logic [DEPTH-1:0]          vld_reg;
    logic                      rd_vld_reg;
    logic                      byp_reg;
    logic [tbp_pkg::CTR_W-1:0] byp_data_reg;
    logic [tbp_pkg::CTR_W-1:0] fill_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_mem_reg <= mem[rd_addr];
            byp_data_reg <= clr ? clr_fill : wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            byp_reg    <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (clr)
            begin
                vld_reg  <= '0;
                fill_reg <= clr_fill;
            end
            else if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
                byp_reg    <= clr || (wr.en && (wr.addr == rd_addr));
            end
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : (rd_vld_reg ? rd_mem_reg : fill_reg);

endmodule

>>> design/tournament_branch_predictor_core.sv
// Top level of the tournament branch predictor: local, global and chooser tables.
// Items and results are registered; one item per cycle is sustained while m_tready is high.
// The table read is registered with the input item, then prediction and training complete.
// Reset clears histories, valid bits and control at once; no clearing pass is needed.
// Depends on tbp_pkg, tbp_apb_regs and tbp_ctr_tbl.
module tournament_branch_predictor_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbp_pkg::APB_AW-1:0]  paddr,
    input  logic [tbp_pkg::APB_DW-1:0]  pwdata,
    output logic [tbp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tbp_pkg::IN_DW-1:0]   s_tdata,   // pc[2:0], taken[3], zero fill
    input  logic                        s_tuser,   // opcode[0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tbp_pkg::OUT_DW-1:0]  m_tdata    // predicted_taken[0], chose_global[1],
                                                   // correct[2], zero fill
);

    tbp_pkg::cfg_t cfg;

    logic                          s1_valid_reg;
    logic                          s1_op_reg;
    logic [tbp_pkg::SLOT_W-1:0]    s1_slot_reg;
    logic                          s1_taken_reg;
    logic [tbp_pkg::LHIST_W-1:0]   s1_lh_reg;
    logic [tbp_pkg::GHIST_W-1:0]   s1_gidx_reg;
    logic [tbp_pkg::GHIST_W-1:0]   ghist_reg;
    logic [tbp_pkg::GHIST_W-1:0]   ghist_next;
    logic [tbp_pkg::LHIST_W-1:0]   lhist_reg [tbp_pkg::NUM_SLOTS];
    logic [tbp_pkg::LHIST_W-1:0]   lh_next;
    logic                          m_valid_reg;
    logic [tbp_pkg::OUT_DW-1:0]    m_data_reg;

    logic                          accept;
    logic                          s1_adv;
    logic                          clr_adv;
    logic                          br_adv;
    logic [tbp_pkg::HB_W-1:0]      p;
    logic [tbp_pkg::GHIST_W-1:0]   gm;
    logic [tbp_pkg::SLOT_W-1:0]    in_pc;
    logic [tbp_pkg::GHIST_W-1:0]   gidx0;
    logic [tbp_pkg::LHIST_W-1:0]   lh0;
    logic [tbp_pkg::LHIST_W-1:0]   lh_fill;
    logic [tbp_pkg::CTR_W-1:0]     ctr_fill;

    logic [tbp_pkg::CTR_W-1:0]     l_ctr;
    logic [tbp_pkg::CTR_W-1:0]     g_ctr;
    logic [tbp_pkg::CTR_W-1:0]     ch_rd_data;
    logic [tbp_pkg::CTR_W-1:0]     ch_ctr;
    logic                          use_g;
    logic [tbp_pkg::CTR_W-1:0]     sel_ctr;
    logic                          pred;
    logic                          hit;
    tbp_pkg::tbl_wr_t              l_wr;
    tbp_pkg::tbl_wr_t              g_wr;
    tbp_pkg::tbl_wr_t              ch_wr;

    tbp_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign p        = tbp_pkg::eff_bits(cfg.history_bits);
    assign gm       = tbp_pkg::gmask(p);
    assign lh_fill  = cfg.init_all_ones ? {tbp_pkg::LHIST_W{1'b1}} : '0;
    assign ctr_fill = cfg.init_all_ones ? {tbp_pkg::CTR_W{1'b1}} : '0;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;
    assign clr_adv  = s1_adv && (s1_op_reg == tbp_pkg::OP_CLEAR);
    assign br_adv   = s1_adv && (s1_op_reg == tbp_pkg::OP_BRANCH);
    assign in_pc    = s_tdata[tbp_pkg::SLOT_W-1:0];

    assign ch_ctr  = ch_rd_data;
    assign use_g   = ch_ctr[tbp_pkg::CTR_W-1];
    assign sel_ctr = use_g ? g_ctr : l_ctr;
    assign pred    = sel_ctr[tbp_pkg::CTR_W-1];
    assign hit     = (pred == s1_taken_reg);

    assign lh_next = {s1_taken_reg, s1_lh_reg[tbp_pkg::LHIST_W-1:1]};

    always_comb
    begin
        if (s1_op_reg == tbp_pkg::OP_CLEAR)
        begin
            ghist_next = '0;
        end
        else
        begin
            ghist_next = ((tbp_pkg::GHIST_W'(s1_taken_reg) << (p - tbp_pkg::HB_W'(1)))
                         | (s1_gidx_reg >> 1)) & gm;
        end
    end

    assign gidx0 = (s1_adv ? ghist_next : ghist_reg) & gm;

    always_comb
    begin
        if (clr_adv)
        begin
            lh0 = lh_fill;
        end
        else if (br_adv && (s1_slot_reg == in_pc))
        begin
            lh0 = lh_next;
        end
        else
        begin
            lh0 = lhist_reg[in_pc];
        end
    end

    always_comb
    begin
        l_wr.en    = br_adv && !use_g;
        l_wr.addr  = {s1_slot_reg, s1_lh_reg};
        l_wr.data  = tbp_pkg::sat_move(l_ctr, s1_taken_reg);
        g_wr.en    = br_adv && use_g;
        g_wr.addr  = s1_gidx_reg;
        g_wr.data  = tbp_pkg::sat_move(g_ctr, s1_taken_reg);
        ch_wr.en   = br_adv;
        ch_wr.addr = s1_gidx_reg;
        ch_wr.data = tbp_pkg::sat_move(ch_ctr, use_g ? hit : !hit);
    end

    tbp_ctr_tbl u_local
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  ({in_pc, lh0}),
        .wr       (l_wr),
        .clr      (clr_adv),
        .clr_fill (ctr_fill),
        .rd_data  (l_ctr)
    );

    tbp_ctr_tbl u_global
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (gidx0),
        .wr       (g_wr),
        .clr      (clr_adv),
        .clr_fill (ctr_fill),
        .rd_data  (g_ctr)
    );

    tbp_ctr_tbl u_chooser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (gidx0),
        .wr       (ch_wr),
        .clr      (clr_adv),
        .clr_fill (ctr_fill),
        .rd_data  (ch_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= s_tuser;
            s1_slot_reg  <= in_pc;
            s1_taken_reg <= s_tdata[tbp_pkg::SLOT_W];
            s1_lh_reg    <= lh0;
            s1_gidx_reg  <= gidx0;
        end
        if (s1_adv)
        begin
            if (s1_op_reg == tbp_pkg::OP_BRANCH)
            begin
                m_data_reg <= tbp_pkg::OUT_DW'({hit, use_g, pred});
            end
            else
            begin
                m_data_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            ghist_reg    <= '0;
            for (int i = 0; i < tbp_pkg::NUM_SLOTS; i++)
            begin
                lhist_reg[i] <= '0;
            end
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_adv)
            begin
                m_valid_reg <= 1'b1;
                ghist_reg   <= ghist_next;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (clr_adv)
            begin
                for (int i = 0; i < tbp_pkg::NUM_SLOTS; i++)
                begin
                    lhist_reg[i] <= lh_fill;
                end
            end
            else if (br_adv)
            begin
                lhist_reg[s1_slot_reg] <= lh_next;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A clear item reports all zeros and leaves the global history empty.
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        clr_adv |=> (m_tdata == '0) && (ghist_reg == '0))
        else $error("clear item result or history not zero");

    // The correct flag agrees with the prediction and the outcome.
    a_correct_flag: assert property (@(posedge clk) disable iff (!rst_n)
        br_adv |=> m_tdata[2] == (m_tdata[0] == $past(s1_taken_reg)))
        else $error("correct flag inconsistent with prediction");

    // The global history never holds bits above the active length.
    a_ghist_mask: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (ghist_reg & ~$past(gm)) == '0)
        else $error("global history exceeds active length");

    // A branch item shifts its outcome into the top of its slot history.
    a_lhist_shift: assert property (@(posedge clk) disable iff (!rst_n)
        br_adv |=> lhist_reg[$past(s1_slot_reg)][tbp_pkg::LHIST_W-1] == $past(s1_taken_reg))
        else $error("local history not updated with outcome");

endmodule

>>> tb/sv/tbp_branch_checker.sv
// Checker for the tournament branch predictor: watches the APB port and both streams.
// It keeps its own copy of the tables and registers, predicts every result and compares.
// Depends on tbp_pkg for widths and codes.
module tbp_branch_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tbp_pkg::APB_AW-1:0] paddr,
    input  logic [tbp_pkg::APB_DW-1:0] pwdata,
    input  logic [tbp_pkg::APB_DW-1:0] prdata,
    input  logic                       pready,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [tbp_pkg::IN_DW-1:0]  s_tdata,   // pc[2:0], taken[3], zero fill
    input  logic                       s_tuser,   // opcode[0]
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [tbp_pkg::OUT_DW-1:0] m_tdata,   // predicted_taken[0], chose_global[1], correct[2]
    output int                         mismatches,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic hit;
        logic chose_global;
        logic predicted_taken;
    } verdict_t;

    logic [tbp_pkg::LHIST_W-1:0] slot_history [tbp_pkg::NUM_SLOTS];
    logic [tbp_pkg::CTR_W-1:0]   local_ctr    [1 << tbp_pkg::LIDX_W];
    logic [tbp_pkg::CTR_W-1:0]   global_ctr   [1 << tbp_pkg::GHIST_W];
    logic [tbp_pkg::CTR_W-1:0]   chooser_ctr  [1 << tbp_pkg::GHIST_W];
    logic [tbp_pkg::GHIST_W-1:0] path_history;
    logic [tbp_pkg::HB_W-1:0]    hist_len;
    logic                        fill_ones;
    verdict_t                    awaited [$];

    function automatic logic [tbp_pkg::CTR_W-1:0] bump(input logic [tbp_pkg::CTR_W-1:0] c,
                                                       input logic up);
        if (up)
        begin
            return (c == '1) ? c : c + tbp_pkg::CTR_W'(1);
        end
        return (c == '0) ? c : c - tbp_pkg::CTR_W'(1);
    endfunction

    function automatic void wipe_tables(input logic ones);
        foreach (slot_history[i]) slot_history[i] = {tbp_pkg::LHIST_W{ones}};
        foreach (local_ctr[i]) local_ctr[i] = {tbp_pkg::CTR_W{ones}};
        foreach (global_ctr[i]) global_ctr[i] = {tbp_pkg::CTR_W{ones}};
        foreach (chooser_ctr[i]) chooser_ctr[i] = {tbp_pkg::CTR_W{ones}};
        path_history = '0;
    endfunction

    function automatic verdict_t resolve_branch(input logic [tbp_pkg::SLOT_W-1:0] slot,
                                                input logic tk);
        int                          p;
        logic [tbp_pkg::GHIST_W-1:0] mask;
        logic [tbp_pkg::GHIST_W-1:0] gidx;
        logic [tbp_pkg::LHIST_W-1:0] lh;
        logic [tbp_pkg::LIDX_W-1:0]  lidx;
        verdict_t                    v;
        p = (hist_len == 0) ? 1 :
            (hist_len > tbp_pkg::GHIST_W) ? tbp_pkg::GHIST_W : int'(hist_len);
        mask = tbp_pkg::GHIST_W'((1 << p) - 1);
        gidx = path_history & mask;
        lh = slot_history[slot];
        lidx = {slot, lh};
        v.chose_global = chooser_ctr[gidx] >= 2;
        v.predicted_taken = v.chose_global ? (global_ctr[gidx] >= 2) : (local_ctr[lidx] >= 2);
        v.hit = (v.predicted_taken == tk);
        if (v.chose_global)
        begin
            global_ctr[gidx] = bump(global_ctr[gidx], tk);
            chooser_ctr[gidx] = bump(chooser_ctr[gidx], v.hit);
        end
        else
        begin
            local_ctr[lidx] = bump(local_ctr[lidx], tk);
            chooser_ctr[gidx] = bump(chooser_ctr[gidx], !v.hit);
        end
        slot_history[slot] = {tk, lh[tbp_pkg::LHIST_W-1:1]};
        path_history = ((tbp_pkg::GHIST_W'(tk) << (p - 1)) | (gidx >> 1)) & mask;
        return v;
    endfunction

    function automatic void check_field(input string field,
                                        input logic [tbp_pkg::APB_DW-1:0] want,
                                        input logic [tbp_pkg::APB_DW-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t                   got;
        verdict_t                   want;
        logic [tbp_pkg::APB_AW-3:0] reg_index;
        if (!rst_n)
        begin
            hist_len = tbp_pkg::HB_W'(3);
            fill_ones = 1'b0;
            wipe_tables(1'b0);
            awaited.delete();
            outstanding = 0;
            mismatches = 0;
        end
        else
        begin
            reg_index = paddr[tbp_pkg::APB_AW-1:2];
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (reg_index == tbp_pkg::REG_HIST_BITS)
                    begin
                        hist_len = pwdata[tbp_pkg::HB_W-1:0];
                    end
                    else if (reg_index == tbp_pkg::REG_INIT_ONES)
                    begin
                        fill_ones = pwdata[0];
                    end
                end
                else if (reg_index == tbp_pkg::REG_HIST_BITS)
                begin
                    check_field("prdata history_bits", tbp_pkg::APB_DW'(hist_len), prdata);
                end
                else
                begin
                    check_field("prdata init_all_ones", tbp_pkg::APB_DW'(fill_ones), prdata);
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (awaited.size() == 0)
                begin
                    $error("result with no expectation waiting: m_tdata %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = awaited.pop_front();
                    got.predicted_taken = m_tdata[0];
                    got.chose_global = m_tdata[1];
                    got.hit = m_tdata[2];
                    check_field("predicted_taken", tbp_pkg::APB_DW'(want.predicted_taken),
                                tbp_pkg::APB_DW'(got.predicted_taken));
                    check_field("chose_global", tbp_pkg::APB_DW'(want.chose_global),
                                tbp_pkg::APB_DW'(got.chose_global));
                    check_field("correct", tbp_pkg::APB_DW'(want.hit),
                                tbp_pkg::APB_DW'(got.hit));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == tbp_pkg::OP_CLEAR)
                begin
                    wipe_tables(fill_ones);
                    awaited.push_back('0);
                end
                else
                begin
                    awaited.push_back(resolve_branch(s_tdata[tbp_pkg::SLOT_W-1:0],
                                                     s_tdata[tbp_pkg::SLOT_W]));
                end
            end
            outstanding = awaited.size();
        end
    end

endmodule

>>> tb/sv/tb_tournament_branch_predictor_core.sv
// Top of the tournament branch predictor testbench: clock, reset, stimulus and verdict.
// Drives directed and pattern-driven random branch items, clears and register settings.
// Depends on tbp_pkg, tournament_branch_predictor_core and tbp_branch_checker.
module tb_tournament_branch_predictor_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 140;

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       psel     = 1'b0;
    logic                       penable  = 1'b0;
    logic                       pwrite   = 1'b0;
    logic [tbp_pkg::APB_AW-1:0] paddr    = '0;
    logic [tbp_pkg::APB_DW-1:0] pwdata   = '0;
    logic [tbp_pkg::APB_DW-1:0] prdata;
    logic                       pready;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [tbp_pkg::IN_DW-1:0]  s_tdata  = '0;
    logic                       s_tuser  = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [tbp_pkg::OUT_DW-1:0] m_tdata;
    int                         mismatches;
    int                         outstanding;

    bit                         steady_send;
    bit                         steady_recv;
    int                         branch_count;
    int                         clear_count;
    int                         write_count;
    int                         cycles;
    logic [7:0]                 motif  [tbp_pkg::NUM_SLOTS];
    int                         period [tbp_pkg::NUM_SLOTS];
    int                         beat   [tbp_pkg::NUM_SLOTS];

    tournament_branch_predictor_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tbp_branch_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $error("run timed out with %0d results outstanding", outstanding);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [tbp_pkg::SLOT_W-1:0] pc,
                             input logic tk);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= tbp_pkg::IN_DW'({tk, pc});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op == tbp_pkg::OP_CLEAR)
        begin
            clear_count++;
        end
        else
        begin
            branch_count++;
        end
    endtask

    task automatic branch(input logic [tbp_pkg::SLOT_W-1:0] pc, input logic tk);
        send_item(tbp_pkg::OP_BRANCH, pc, tk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic reg_index,
                              input logic [tbp_pkg::APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= tbp_pkg::APB_AW'({reg_index, 2'b00});
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int hb, input int ones);
        settle();
        apb_access(1'b1, tbp_pkg::REG_HIST_BITS, tbp_pkg::APB_DW'(hb));
        apb_access(1'b1, tbp_pkg::REG_INIT_ONES, tbp_pkg::APB_DW'(ones));
        apb_access(1'b0, tbp_pkg::REG_HIST_BITS, '0);
        apb_access(1'b0, tbp_pkg::REG_INIT_ONES, '0);
        write_count += 2;
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady_recv ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial
    begin
        int                         phase_hb   [PHASES] = '{3, 0, 7, 6, 1, 2, 4, 5, 6};
        int                         phase_ones [PHASES] = '{0, 1, 0, 1, 0, 1, 1, 0, 1};
        logic [tbp_pkg::SLOT_W-1:0] hot [2];
        logic [tbp_pkg::SLOT_W-1:0] pc;
        logic                       tk;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, tbp_pkg::REG_HIST_BITS, '0);
        apb_access(1'b0, tbp_pkg::REG_INIT_ONES, '0);

        branch(3'd0, 1'b0);
        branch(3'd7, 1'b1);
        branch(3'd7, 1'b1);
        branch(3'd3, 1'b1);
        send_item(tbp_pkg::OP_CLEAR, 3'd5, 1'b1);
        branch(3'd5, 1'b0);
        set_config(0, 1);
        send_item(tbp_pkg::OP_CLEAR, 3'd0, 1'b0);
        branch(3'd2, 1'b0);
        branch(3'd2, 1'b1);
        branch(3'd6, 1'b0);
        set_config(7, 1);
        branch(3'd1, 1'b1);
        branch(3'd4, 1'b0);
        branch(3'd1, 1'b1);
        send_item(tbp_pkg::OP_CLEAR, 3'd7, 1'b1);
        for (int i = 0; i < 4; i++)
        begin
            branch(tbp_pkg::SLOT_W'(2 * i), 1'(i));
        end
        set_config(6, 0);
        branch(3'd7, 1'b1);
        branch(3'd7, 1'b0);
        set_config(1, 0);
        branch(3'd3, 1'b1);
        branch(3'd3, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_config(phase_hb[ph], phase_ones[ph]);
            steady_send = (ph % 3 == 1);
            steady_recv = (ph % 3 == 2);
            if (ph % 2 == 0)
            begin
                send_item(tbp_pkg::OP_CLEAR, tbp_pkg::SLOT_W'($urandom), 1'($urandom));
            end
            hot[0] = tbp_pkg::SLOT_W'($urandom);
            hot[1] = tbp_pkg::SLOT_W'($urandom);
            for (int s = 0; s < tbp_pkg::NUM_SLOTS; s++)
            begin
                motif[s] = 8'($urandom);
                period[s] = $urandom_range(1, 8);
                beat[s] = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2 && ph % 2 == 1)
                begin
                    settle();
                end
                if ($urandom_range(0, 79) == 0)
                begin
                    send_item(tbp_pkg::OP_CLEAR, tbp_pkg::SLOT_W'($urandom), 1'($urandom));
                end
                else
                begin
                    pc = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 1)]
                                                     : tbp_pkg::SLOT_W'($urandom_range(0, 7));
                    tk = motif[pc][beat[pc] % period[pc]];
                    beat[pc]++;
                    if ($urandom_range(0, 11) == 0)
                    begin
                        tk = 1'($urandom);
                    end
                    branch(pc, tk);
                end
            end
        end
        steady_send = 1'b0;
        steady_recv = 1'b0;
        settle();

        $display("Covered %0d branch items and %0d clears across %0d register writes.",
                 branch_count, clear_count, write_count);
        $display("History lengths 0 to 7 and both table fills were used, with and without gaps.");
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
design/tbp_pkg.sv
design/tbp_apb_regs.sv
design/tbp_ctr_tbl.sv
design/tournament_branch_predictor_core.sv
tb/sv/tbp_branch_checker.sv
tb/sv/tb_tournament_branch_predictor_core.sv
